>>> rtl/core/prn_pkg.sv
// shared types, constants and microcode encoding for the pitch ratio normalizer
package prn_pkg;

  localparam int IN_W           = 16;
  localparam int OCT_IN_W       = 7;
  localparam int OUT_W          = 17;
  localparam int OCT_W          = 8;
  localparam int TERM_WIDTH_DEF = 16;
  localparam int PC_W           = 4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DBL_NUM,
    OP_DBL_DEN,
    OP_HALVE,
    OP_LOAD_GCD,
    OP_STEIN,
    OP_DIV_LD_NUM,
    OP_DIV_STEP,
    OP_DIV_LD_DEN,
    OP_EMIT,
    OP_EMIT_NULL
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NULL,
    C_NUM_LT_DEN,
    C_NUM_GE_2DEN,
    C_BOTH_EVEN,
    C_X_NE_Y,
    C_DIV_RUN
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             last;
  } ucode_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } prn_ctrl_t;

  typedef struct packed {
    logic is_null;
    logic num_lt_den;
    logic num_ge_2den;
    logic both_even;
    logic x_ne_y;
    logic div_run;
  } prn_status_t;

endpackage

>>> rtl/core/prn_ucode_rom.sv
// microcode program: one control word per step
module prn_ucode_rom (
  input  logic [prn_pkg::PC_W-1:0] pc,
  output prn_pkg::ucode_t          word
);

  localparam logic [prn_pkg::PC_W-1:0] L_CHECK    = 4'd0;
  localparam logic [prn_pkg::PC_W-1:0] L_DBL_NUM  = 4'd1;
  localparam logic [prn_pkg::PC_W-1:0] L_DBL_DEN  = 4'd2;
  localparam logic [prn_pkg::PC_W-1:0] L_HALVE    = 4'd3;
  localparam logic [prn_pkg::PC_W-1:0] L_LOAD_GCD = 4'd4;
  localparam logic [prn_pkg::PC_W-1:0] L_STEIN    = 4'd5;
  localparam logic [prn_pkg::PC_W-1:0] L_DIV_NUM  = 4'd6;
  localparam logic [prn_pkg::PC_W-1:0] L_DIV_LP1  = 4'd7;
  localparam logic [prn_pkg::PC_W-1:0] L_DIV_DEN  = 4'd8;
  localparam logic [prn_pkg::PC_W-1:0] L_DIV_LP2  = 4'd9;
  localparam logic [prn_pkg::PC_W-1:0] L_EMIT     = 4'd10;
  localparam logic [prn_pkg::PC_W-1:0] L_EMIT_NUL = 4'd11;

  always_comb begin
    unique case (pc)
      L_CHECK:    word = '{prn_pkg::OP_NOP,        prn_pkg::C_NULL,        L_EMIT_NUL, 1'b0};
      L_DBL_NUM:  word = '{prn_pkg::OP_DBL_NUM,    prn_pkg::C_NUM_LT_DEN,  L_DBL_NUM,  1'b0};
      L_DBL_DEN:  word = '{prn_pkg::OP_DBL_DEN,    prn_pkg::C_NUM_GE_2DEN, L_DBL_DEN,  1'b0};
      L_HALVE:    word = '{prn_pkg::OP_HALVE,      prn_pkg::C_BOTH_EVEN,   L_HALVE,    1'b0};
      L_LOAD_GCD: word = '{prn_pkg::OP_LOAD_GCD,   prn_pkg::C_ALWAYS,      L_STEIN,    1'b0};
      L_STEIN:    word = '{prn_pkg::OP_STEIN,      prn_pkg::C_X_NE_Y,      L_STEIN,    1'b0};
      L_DIV_NUM:  word = '{prn_pkg::OP_DIV_LD_NUM, prn_pkg::C_ALWAYS,      L_DIV_LP1,  1'b0};
      L_DIV_LP1:  word = '{prn_pkg::OP_DIV_STEP,   prn_pkg::C_DIV_RUN,     L_DIV_LP1,  1'b0};
      L_DIV_DEN:  word = '{prn_pkg::OP_DIV_LD_DEN, prn_pkg::C_ALWAYS,      L_DIV_LP2,  1'b0};
      L_DIV_LP2:  word = '{prn_pkg::OP_DIV_STEP,   prn_pkg::C_DIV_RUN,     L_DIV_LP2,  1'b0};
      L_EMIT:     word = '{prn_pkg::OP_EMIT,       prn_pkg::C_ALWAYS,      L_CHECK,    1'b1};
      L_EMIT_NUL: word = '{prn_pkg::OP_EMIT_NULL,  prn_pkg::C_ALWAYS,      L_CHECK,    1'b1};
      default:    word = '{prn_pkg::OP_NOP,        prn_pkg::C_ALWAYS,      L_CHECK,    1'b1};
    endcase
  end

endmodule

>>> rtl/core/prn_datapath.sv
// datapath: term registers, octave counter, gcd and bit-serial divider
module prn_datapath #(
  parameter int TERM_WIDTH = prn_pkg::TERM_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  prn_pkg::prn_ctrl_t                ctrl,
  input  logic [prn_pkg::IN_W-1:0]          in_ratio_num,
  input  logic [prn_pkg::IN_W-1:0]          in_ratio_den,
  input  logic signed [prn_pkg::OCT_IN_W-1:0] in_octave_in,
  output prn_pkg::prn_status_t              status,
  output logic                              out_valid,
  output logic [prn_pkg::OUT_W-1:0]         out_norm_num,
  output logic [prn_pkg::OUT_W-1:0]         out_norm_den,
  output logic signed [prn_pkg::OCT_W-1:0]  out_octave_out,
  output logic                              out_is_null
);

  localparam int DW = TERM_WIDTH + 1;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] x_r, x_nxt;
  logic [DW-1:0] y_r, y_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [prn_pkg::OCT_W-1:0] oct_r, oct_nxt;
  logic null_r, null_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [prn_pkg::OUT_W-1:0] onum_r, onum_nxt;
  logic [prn_pkg::OUT_W-1:0] oden_r, oden_nxt;
  logic [prn_pkg::OCT_W-1:0] ooct_r, ooct_nxt;
  logic onull_r, onull_nxt;

  logic [TERM_WIDTH+prn_pkg::IN_W-1:0] num_wide, den_wide;
  logic [DW-1:0] load_num, load_den;
  logic [DW-1:0] x_minus_y, y_minus_x;
  logic [DW:0]   trial;
  logic [DW+prn_pkg::OUT_W-1:0] num_out_wide, den_out_wide;

  always_comb begin
    num_wide     = {{TERM_WIDTH{1'b0}}, in_ratio_num};
    den_wide     = {{TERM_WIDTH{1'b0}}, in_ratio_den};
    load_num     = {1'b0, num_wide[TERM_WIDTH-1:0]};
    load_den     = {1'b0, den_wide[TERM_WIDTH-1:0]};
    x_minus_y    = x_r - y_r;
    y_minus_x    = y_r - x_r;
    trial        = {rem_r, q_r[DW-1]} - {1'b0, x_r};
    num_out_wide = {{prn_pkg::OUT_W{1'b0}}, num_r};
    den_out_wide = {{prn_pkg::OUT_W{1'b0}}, q_r};
  end

  always_comb begin
    status.is_null     = null_r;
    status.num_lt_den  = num_r < den_r;
    status.num_ge_2den = {1'b0, num_r} >= {den_r, 1'b0};
    status.both_even   = !num_r[0] && !den_r[0];
    status.x_ne_y      = x_r != y_r;
    status.div_run     = cnt_r != CW'(DW);
  end

  always_comb begin
    num_nxt       = num_r;
    den_nxt       = den_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    oct_nxt       = oct_r;
    null_nxt      = null_r;
    out_valid_nxt = 1'b0;
    onum_nxt      = onum_r;
    oden_nxt      = oden_r;
    ooct_nxt      = ooct_r;
    onull_nxt     = onull_r;
    if (ctrl.load) begin
      num_nxt  = load_num;
      den_nxt  = load_den;
      oct_nxt  = {in_octave_in[prn_pkg::OCT_IN_W-1], in_octave_in};
      null_nxt = (load_num == '0) || (load_den == '0);
    end else begin
      unique case (ctrl.op)
        prn_pkg::OP_NOP: begin
        end
        prn_pkg::OP_DBL_NUM: begin
          num_nxt = {num_r[DW-2:0], 1'b0};
          oct_nxt = oct_r - prn_pkg::OCT_W'(1);
        end
        prn_pkg::OP_DBL_DEN: begin
          den_nxt = {den_r[DW-2:0], 1'b0};
          oct_nxt = oct_r + prn_pkg::OCT_W'(1);
        end
        prn_pkg::OP_HALVE: begin
          num_nxt = {1'b0, num_r[DW-1:1]};
          den_nxt = {1'b0, den_r[DW-1:1]};
        end
        prn_pkg::OP_LOAD_GCD: begin
          x_nxt = num_r;
          y_nxt = den_r;
        end
        prn_pkg::OP_STEIN: begin
          if (!x_r[0]) begin
            x_nxt = {1'b0, x_r[DW-1:1]};
          end else if (!y_r[0]) begin
            y_nxt = {1'b0, y_r[DW-1:1]};
          end else if (x_r > y_r) begin
            x_nxt = {1'b0, x_minus_y[DW-1:1]};
          end else begin
            y_nxt = {1'b0, y_minus_x[DW-1:1]};
          end
        end
        prn_pkg::OP_DIV_LD_NUM: begin
          q_nxt   = num_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end
        prn_pkg::OP_DIV_LD_DEN: begin
          num_nxt = q_r;
          q_nxt   = den_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end
        prn_pkg::OP_DIV_STEP: begin
          if (!trial[DW]) begin
            rem_nxt = trial[DW-1:0];
            q_nxt   = {q_r[DW-2:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[DW-2:0], q_r[DW-1]};
            q_nxt   = {q_r[DW-2:0], 1'b0};
          end
          cnt_nxt = cnt_r + CW'(1);
        end
        prn_pkg::OP_EMIT: begin
          out_valid_nxt = 1'b1;
          onum_nxt      = num_out_wide[prn_pkg::OUT_W-1:0];
          oden_nxt      = den_out_wide[prn_pkg::OUT_W-1:0];
          ooct_nxt      = oct_r;
          onull_nxt     = 1'b0;
        end
        prn_pkg::OP_EMIT_NULL: begin
          out_valid_nxt = 1'b1;
          onum_nxt      = '0;
          oden_nxt      = '0;
          ooct_nxt      = '0;
          onull_nxt     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    oct_r   <= oct_nxt;
    null_r  <= null_nxt;
    onum_r  <= onum_nxt;
    oden_r  <= oden_nxt;
    ooct_r  <= ooct_nxt;
    onull_r <= onull_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_norm_num   = onum_r;
  assign out_norm_den   = oden_r;
  assign out_octave_out = ooct_r;
  assign out_is_null    = onull_r;

endmodule

>>> rtl/core/prn_sequencer.sv
// step counter, condition select and jump logic around the microcode rom
module prn_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  prn_pkg::prn_status_t status,
  output prn_pkg::prn_ctrl_t   ctrl,
  output logic                 busy
);

  logic [prn_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     busy_r, busy_nxt;
  prn_pkg::ucode_t          word;
  logic                     cond_true;

  prn_ucode_rom u_rom (
    .pc   (pc_r),
    .word (word)
  );

  always_comb begin
    unique case (word.cond)
      prn_pkg::C_ALWAYS:      cond_true = 1'b1;
      prn_pkg::C_NULL:        cond_true = status.is_null;
      prn_pkg::C_NUM_LT_DEN:  cond_true = status.num_lt_den;
      prn_pkg::C_NUM_GE_2DEN: cond_true = status.num_ge_2den;
      prn_pkg::C_BOTH_EVEN:   cond_true = status.both_even;
      prn_pkg::C_X_NE_Y:      cond_true = status.x_ne_y;
      prn_pkg::C_DIV_RUN:     cond_true = status.div_run;
      default:                cond_true = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt    = pc_r;
    busy_nxt  = busy_r;
    ctrl.load = start && !busy_r;
    ctrl.op   = prn_pkg::OP_NOP;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else if (cond_true) begin
      ctrl.op = word.op;
      if (word.last) begin
        busy_nxt = 1'b0;
        pc_nxt   = '0;
      end else begin
        pc_nxt = word.target;
      end
    end else begin
      pc_nxt = pc_r + prn_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

>>> rtl/core/pitch_ratio_normalizer_top.sv
// top level of the pitch ratio normalizer
//
// an item (ratio_num, ratio_den, octave_in) is taken at a clock edge with
// start high and busy low; busy then stays high until the result is out.
// the block doubles the smaller term until the ratio lies in [1,2), tracks
// the octave, reduces the terms to lowest terms and shows one result on the
// out_ ports for exactly one cycle with out_valid high.
// busy falls at the edge that raises out_valid, so the next start may be
// taken in the cycle where the result is shown.
// a null item (either term zero) goes from the check step straight to the
// null result; other items pass through the doublings, the halving of
// common factors of two, the gcd loop and the two bit-serial divides,
// which run one microcode step per cycle on one shared datapath.
// the receiver cannot stall: every result is taken in the cycle it is shown.
// synchronous reset clears busy and out_valid; no item is in flight after it.
module pitch_ratio_normalizer_top #(
  parameter int TERM_WIDTH = prn_pkg::TERM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [prn_pkg::IN_W-1:0]            in_ratio_num,
  input  logic [prn_pkg::IN_W-1:0]            in_ratio_den,
  input  logic signed [prn_pkg::OCT_IN_W-1:0] in_octave_in,
  output logic                                out_valid,
  output logic [prn_pkg::OUT_W-1:0]           out_norm_num,
  output logic [prn_pkg::OUT_W-1:0]           out_norm_den,
  output logic signed [prn_pkg::OCT_W-1:0]    out_octave_out,
  output logic                                out_is_null
);

  prn_pkg::prn_ctrl_t   ctrl;
  prn_pkg::prn_status_t status;

  prn_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  prn_datapath #(
    .TERM_WIDTH (TERM_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_ratio_num   (in_ratio_num),
    .in_ratio_den   (in_ratio_den),
    .in_octave_in   (in_octave_in),
    .status         (status),
    .out_valid      (out_valid),
    .out_norm_num   (out_norm_num),
    .out_norm_den   (out_norm_den),
    .out_octave_out (out_octave_out),
    .out_is_null    (out_is_null)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted item");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result shown outside end of an item");

  a_lowest_terms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_null |-> out_norm_num[0] || out_norm_den[0])
    else $error("result terms share a factor of two");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule

>>> bench/testbench.sv
// self-checking bench for pitch_ratio_normalizer_top: directed and random ratios
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [prn_pkg::IN_W-1:0]            num;
    logic [prn_pkg::IN_W-1:0]            den;
    logic signed [prn_pkg::OCT_IN_W-1:0] oct;
  } ratio_item_t;

  typedef struct {
    logic [prn_pkg::OUT_W-1:0]        num;
    logic [prn_pkg::OUT_W-1:0]        den;
    logic signed [prn_pkg::OCT_W-1:0] oct;
    logic                             null_flag;
  } interval_t;

  localparam logic [63:0] TERM_MASK = (64'd1 << prn_pkg::TERM_WIDTH_DEF) - 64'd1;
  localparam int RANDOM_ITEMS = 1200;
  localparam int MAX_GAP      = 12;
  localparam int DRAIN_CYCLES = 200;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [prn_pkg::IN_W-1:0]            in_ratio_num = '0;
  logic [prn_pkg::IN_W-1:0]            in_ratio_den = '0;
  logic signed [prn_pkg::OCT_IN_W-1:0] in_octave_in = '0;
  logic                                out_valid;
  logic [prn_pkg::OUT_W-1:0]           out_norm_num;
  logic [prn_pkg::OUT_W-1:0]           out_norm_den;
  logic signed [prn_pkg::OCT_W-1:0]    out_octave_out;
  logic                                out_is_null;

  ratio_item_t pending_ratios[$];
  ratio_item_t ratio_on_port;
  interval_t   expected_intervals[$];
  int          mismatch_count = 0;
  int          gap_left = 0;
  int          no_idle_left = 0;

  pitch_ratio_normalizer_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_ratio_num  (in_ratio_num),
    .in_ratio_den  (in_ratio_den),
    .in_octave_in  (in_octave_in),
    .out_valid     (out_valid),
    .out_norm_num  (out_norm_num),
    .out_norm_den  (out_norm_den),
    .out_octave_out(out_octave_out),
    .out_is_null   (out_is_null)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic interval_t normalize_ratio(ratio_item_t it);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    int          oct;
    interval_t   res;
    n = 64'(it.num) & TERM_MASK;
    d = 64'(it.den) & TERM_MASK;
    oct = int'(it.oct);
    if (n == 0 || d == 0) begin
      res.num = '0;
      res.den = '0;
      res.oct = '0;
      res.null_flag = 1'b1;
      return res;
    end
    while (n < d) begin
      n = n << 1;
      oct = oct - 1;
    end
    while (n >= (d << 1)) begin
      d = d << 1;
      oct = oct + 1;
    end
    a = n;
    b = d;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    n = n / a;
    d = d / a;
    if (oct > 127) oct = 127;
    if (oct < -128) oct = -128;
    res.num = n[prn_pkg::OUT_W-1:0];
    res.den = d[prn_pkg::OUT_W-1:0];
    res.oct = oct[prn_pkg::OCT_W-1:0];
    res.null_flag = 1'b0;
    return res;
  endfunction

  task automatic add_ratio(input logic [prn_pkg::IN_W-1:0] num,
                           input logic [prn_pkg::IN_W-1:0] den,
                           input logic signed [prn_pkg::OCT_IN_W-1:0] oct);
    ratio_item_t it;
    it.num = num;
    it.den = den;
    it.oct = oct;
    pending_ratios.push_back(it);
  endtask

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    interval_t exp_res;
    ratio_item_t it;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        exp_res = normalize_ratio(ratio_on_port);
        expected_intervals.push_back(exp_res);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (pending_ratios.size() != 0) begin
          it = pending_ratios.pop_front();
          ratio_on_port = it;
          in_ratio_num <= it.num;
          in_ratio_den <= it.den;
          in_octave_in <= it.oct;
          start <= 1'b1;
          if (no_idle_left > 0) begin
            no_idle_left = no_idle_left - 1;
            gap_left = 0;
          end else if ($urandom_range(0, 39) == 0) begin
            no_idle_left = $urandom_range(10, 40);
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, MAX_GAP);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    interval_t want;
    if (rst_n && out_valid) begin
      if (expected_intervals.size() == 0) begin
        report($sformatf("result with no item pending: num=%0d den=%0d oct=%0d null=%0b",
                         out_norm_num, out_norm_den, out_octave_out, out_is_null));
      end else begin
        want = expected_intervals.pop_front();
        if (out_norm_num !== want.num)
          report($sformatf("norm_num got %0d want %0d", out_norm_num, want.num));
        if (out_norm_den !== want.den)
          report($sformatf("norm_den got %0d want %0d", out_norm_den, want.den));
        if (out_octave_out !== want.oct)
          report($sformatf("octave_out got %0d want %0d", out_octave_out, want.oct));
        if (out_is_null !== want.null_flag)
          report($sformatf("is_null got %0b want %0b", out_is_null, want.null_flag));
      end
    end
  end

  initial begin
    logic [prn_pkg::IN_W-1:0] n;
    logic [prn_pkg::IN_W-1:0] d;
    int                       k;
    // null cases
    add_ratio(16'd0, 16'd0, 7'sd63);
    add_ratio(16'd0, 16'd5, -7'sd64);
    add_ratio(16'd7, 16'd0, 7'sd21);
    add_ratio(16'd0, 16'hFFFF, 7'sd0);
    add_ratio(16'hFFFF, 16'd0, -7'sd1);
    // unity, extremes and octave extremes
    add_ratio(16'd1, 16'd1, 7'sd0);
    add_ratio(16'hFFFF, 16'hFFFF, 7'sd0);
    add_ratio(16'd1, 16'hFFFF, -7'sd64);
    add_ratio(16'hFFFF, 16'd1, 7'sd63);
    add_ratio(16'd1, 16'hFFFF, 7'sd63);
    add_ratio(16'hFFFF, 16'd1, -7'sd64);
    add_ratio(16'd32768, 16'd1, 7'sd0);
    add_ratio(16'd1, 16'd32768, 7'sd0);
    add_ratio(16'hFFFF, 16'hFFFE, 7'sd5);
    add_ratio(16'hFFFE, 16'hFFFF, -7'sd5);
    // ratios near the bounds 1 and 2
    add_ratio(16'd3, 16'd2, 7'sd0);
    add_ratio(16'd2, 16'd3, 7'sd0);
    add_ratio(16'd2, 16'd1, 7'sd1);
    add_ratio(16'd1024, 16'd256, -7'sd3);
    add_ratio(16'd6, 16'd4, 7'sd0);
    add_ratio(16'd4, 16'd6, 7'sd0);
    add_ratio(16'd45000, 16'd30000, 7'sd10);
    add_ratio(16'd43690, 16'd21845, 7'sd0);
    add_ratio(16'hAAAA, 16'h5555, -7'sd32);
    add_ratio(16'h5555, 16'hAAAA, 7'sd31);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          n = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
          d = (n != 0 || $urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        end
        1, 2: begin
          n = 16'($urandom_range(1, 64));
          d = 16'($urandom_range(1, 64));
        end
        3: begin
          k = $urandom_range(1, 255);
          n = 16'($urandom_range(1, 255) * k);
          d = 16'($urandom_range(1, 255) * k);
        end
        4: begin
          n = 16'($urandom_range(1, 255) << $urandom_range(0, 8));
          d = 16'($urandom_range(1, 255) << $urandom_range(0, 8));
        end
        default: begin
          n = 16'($urandom);
          d = 16'($urandom);
        end
      endcase
      add_ratio(n, d, 7'($urandom));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ratios.size() != 0 || start || expected_intervals.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_intervals.size() != 0)
      report($sformatf("%0d results never arrived", expected_intervals.size()));

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("ERROR: timeout with %0d items unsent, %0d results outstanding",
             pending_ratios.size(), expected_intervals.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> pitch_ratio_normalizer_top.f
rtl/core/prn_pkg.sv
rtl/core/prn_ucode_rom.sv
rtl/core/prn_datapath.sv
rtl/core/prn_sequencer.sv
rtl/core/pitch_ratio_normalizer_top.sv
bench/testbench.sv
